// ----- rtl/mcmf_pkg.sv -----
package mcmf_pkg;

    localparam int MAX_NODES = 32;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int ADDR_W    = 2 * NODE_W;
    localparam int CNT_W     = NODE_W + 1;
    localparam int CAP_W     = 16;
    localparam int COST_W    = 16;
    localparam int CST_W     = COST_W + 1;
    localparam int FLOW_W    = 24;
    localparam int RES_W     = FLOW_W + 1;
    localparam int DIST_W    = 32;
    localparam int TFLOW_W   = 21;
    localparam int TCOST_W   = 48;
    localparam int PROD_W    = FLOW_W + CST_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_ADD   = 2'd1;
    localparam logic [1:0] ACT_SOLVE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SINK       = 2'd2;

    localparam logic signed [FLOW_W-1:0] BN_INF = {1'b0, {(FLOW_W-1){1'b1}}};

    typedef struct packed {
        logic [1:0]               action;
        logic [4:0]               edge_from;
        logic [4:0]               edge_to;
        logic [15:0]              edge_capacity;
        logic signed [15:0]       unit_cost;
    } t_in_item;

    typedef struct packed {
        logic [TFLOW_W-1:0]        total_flow;
        logic signed [TCOST_W-1:0] total_cost;
    } t_out_item;

    typedef struct packed {
        logic [NODE_W-1:0] node_count;
        logic [NODE_W-1:0] source_node;
        logic [NODE_W-1:0] sink_node;
    } t_cfg;

    typedef struct packed {
        logic                     cap_we;
        logic                     cost_we;
        logic                     flow_we;
        logic [ADDR_W-1:0]        addr;
        logic [CAP_W-1:0]         cap_d;
        logic signed [CST_W-1:0]  cost_d;
        logic signed [FLOW_W-1:0] flow_d;
    } t_wr;

endpackage

// ----- rtl/min_cost_max_flow_top.sv -----
// Min-cost max-flow engine (cycle canceling).
// Input channel i_in_valid / o_in_stall carries one request: clear the graph,
// add one edge, or solve. Output channel o_out_valid / i_out_stall carries one
// result (flow value and cost) per solve request; other requests give none.
// Configuration (node count, source, sink) is written on i_cfg_valid /
// o_cfg_ready, which is always ready; write it only while the block is idle.
// Requests are taken one at a time; o_in_stall stays high while one is at work.
// Clear sweeps the capacity and cost memories, one matrix entry per cycle.
// Solve clears the flow matrix, then runs BFS rounds that dequeue vertices and
// push along each augmenting path, Bellman-Ford passes, cycle walks that find
// the bottleneck and then push along each edge, and the final cost sum.
// The edge memories have a single registered read port: every edge visited is
// addressed in one state and its data is evaluated in the next.
// After reset the capacity and cost memories are swept to zero, all 1024
// entries, with o_in_stall high; configuration returns to 31, 1, 2.
// A finished result sits in an output register; while the receiver stalls,
// new requests are still accepted, and a later solve waits only to finish.
module min_cost_max_flow_top
    import mcmf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [NODE_W-1:0]    i_cfg_data
);

    t_cfg                     r_cfg;
    logic                     r_out_valid;
    t_out_item                r_out_data;
    logic                     res_ready, res_valid;
    t_out_item                res;
    logic [ADDR_W-1:0]        rd_addr;
    t_wr                      wr;
    logic [CAP_W-1:0]         cap_q;
    logic signed [CST_W-1:0]  cost_q;
    logic signed [FLOW_W-1:0] flow_q;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign res_ready   = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.node_count  <= NODE_W'(31);
            r_cfg.source_node <= NODE_W'(1);
            r_cfg.sink_node   <= NODE_W'(2);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_NODE_COUNT: r_cfg.node_count  <= i_cfg_data;
                CFG_SOURCE:     r_cfg.source_node <= i_cfg_data;
                CFG_SINK:       r_cfg.sink_node   <= i_cfg_data;
                default:        r_cfg             <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out_data <= res;
        end
    end

    mcmf_store u_store (
        .i_clk     (i_clk),
        .i_rd_addr (rd_addr),
        .i_wr      (wr),
        .o_cap     (cap_q),
        .o_cost    (cost_q),
        .o_flow    (flow_q)
    );

    mcmf_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .i_res_ready (res_ready),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_rd_addr   (rd_addr),
        .o_wr        (wr),
        .i_cap       (cap_q),
        .i_cost      (cost_q),
        .i_flow      (flow_q)
    );

endmodule

// ----- rtl/mcmf_store.sv -----
module mcmf_store
    import mcmf_pkg::*;
(
    input  logic                     i_clk,
    input  logic [ADDR_W-1:0]        i_rd_addr,
    input  t_wr                      i_wr,
    output logic [CAP_W-1:0]         o_cap,
    output logic signed [CST_W-1:0]  o_cost,
    output logic signed [FLOW_W-1:0] o_flow
);

    localparam int DEPTH = MAX_NODES * MAX_NODES;

    logic [CAP_W-1:0]         r_cap_mem  [DEPTH];
    logic signed [CST_W-1:0]  r_cost_mem [DEPTH];
    logic signed [FLOW_W-1:0] r_flow_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr.cap_we) begin
            r_cap_mem[i_wr.addr] <= i_wr.cap_d;
        end
        if (i_wr.cost_we) begin
            r_cost_mem[i_wr.addr] <= i_wr.cost_d;
        end
        if (i_wr.flow_we) begin
            r_flow_mem[i_wr.addr] <= i_wr.flow_d;
        end
        o_cap  <= r_cap_mem[i_rd_addr];
        o_cost <= r_cost_mem[i_rd_addr];
        o_flow <= r_flow_mem[i_rd_addr];
    end

endmodule

// ----- rtl/mcmf_seq.sv -----
module mcmf_seq
    import mcmf_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cfg                     i_cfg,
    input  logic                     i_in_valid,
    input  t_in_item                 i_in_data,
    output logic                     o_in_stall,
    input  logic                     i_res_ready,
    output logic                     o_res_valid,
    output t_out_item                o_res,
    output logic [ADDR_W-1:0]        o_rd_addr,
    output t_wr                      o_wr,
    input  logic [CAP_W-1:0]         i_cap,
    input  logic signed [CST_W-1:0]  i_cost,
    input  logic signed [FLOW_W-1:0] i_flow
);

    localparam logic [4:0] S_CLR      = 5'd0;
    localparam logic [4:0] S_IDLE     = 5'd1;
    localparam logic [4:0] S_ADD1     = 5'd2;
    localparam logic [4:0] S_ADD2     = 5'd3;
    localparam logic [4:0] S_FCLR     = 5'd4;
    localparam logic [4:0] S_BFS_INIT = 5'd5;
    localparam logic [4:0] S_BFS_DEQ  = 5'd6;
    localparam logic [4:0] S_BFS_RD   = 5'd7;
    localparam logic [4:0] S_BFS_EV   = 5'd8;
    localparam logic [4:0] S_AUG_INIT = 5'd9;
    localparam logic [4:0] S_AUG_CHK  = 5'd10;
    localparam logic [4:0] S_AUG_RD   = 5'd11;
    localparam logic [4:0] S_AUG_EV   = 5'd12;
    localparam logic [4:0] S_AUG_W2   = 5'd13;
    localparam logic [4:0] S_BF_INIT  = 5'd14;
    localparam logic [4:0] S_BF_PASS  = 5'd15;
    localparam logic [4:0] S_BF_A     = 5'd16;
    localparam logic [4:0] S_BF_RD    = 5'd17;
    localparam logic [4:0] S_BF_EV    = 5'd18;
    localparam logic [4:0] S_LOC      = 5'd19;
    localparam logic [4:0] S_CYC_P    = 5'd20;
    localparam logic [4:0] S_CYC_RD   = 5'd21;
    localparam logic [4:0] S_CYC_EV   = 5'd22;
    localparam logic [4:0] S_PSH_P    = 5'd23;
    localparam logic [4:0] S_PSH_RD   = 5'd24;
    localparam logic [4:0] S_PSH_EV   = 5'd25;
    localparam logic [4:0] S_PSH_W2   = 5'd26;
    localparam logic [4:0] S_SUM_INIT = 5'd27;
    localparam logic [4:0] S_SUM_RD   = 5'd28;
    localparam logic [4:0] S_SUM_EV   = 5'd29;
    localparam logic [4:0] S_SUM_END  = 5'd30;
    localparam logic [4:0] S_OUT      = 5'd31;

    localparam logic [NODE_W-1:0] NODE_ONE  = NODE_W'(1);
    localparam logic [NODE_W-1:0] NODE_ZERO = '0;
    localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_NODES);

    logic [4:0]                r_state, n_state;
    logic [ADDR_W-1:0]         r_cnt, n_cnt;
    logic [NODE_W-1:0]         r_a, n_a, r_b, n_b, r_u, n_u, r_v, n_v, r_x, n_x;
    logic [NODE_W-1:0]         r_pass, n_pass, r_last, n_last;
    logic [CNT_W-1:0]          r_head, n_head, r_tail, n_tail, r_steps, n_steps;
    logic signed [FLOW_W-1:0]  r_add, n_add, r_bn_a, n_bn_a, r_fnew, n_fnew;
    logic signed [DIST_W-1:0]  r_dist_a, n_dist_a;
    logic [TFLOW_W-1:0]        r_total, n_total;
    logic signed [TCOST_W-1:0] r_acc, n_acc;
    logic signed [PROD_W-1:0]  r_prod, n_prod;
    logic                      r_prod_v, n_prod_v;
    logic [NODE_W-1:0]         r_eu, n_eu, r_ev, n_ev;
    logic [CAP_W-1:0]          r_ecap, n_ecap;
    logic signed [COST_W-1:0]  r_ecost, n_ecost;

    // scratch per vertex
    logic [MAX_NODES-1:0]      r_visited;
    logic [NODE_W-1:0]         r_pred  [MAX_NODES];
    logic [NODE_W-1:0]         r_queue [MAX_NODES];
    logic signed [FLOW_W-1:0]  r_bn    [MAX_NODES];
    logic signed [DIST_W-1:0]  r_dist  [MAX_NODES];

    logic                      init_bfs, init_bf, bfs_take, bf_take;
    logic [NODE_W-1:0]         pred_q, queue_q, bn_idx, dist_idx;
    logic signed [FLOW_W-1:0]  bn_q, bn_new, fnew_c;
    logic signed [DIST_W-1:0]  dist_q;
    logic signed [RES_W-1:0]   resid, add_min;
    logic                      resid_pos;
    logic signed [DIST_W:0]    newd;
    logic signed [PROD_W-1:0]  prod_c;
    logic                      st_ok;
    logic [NODE_W-1:0]         n_cnt_nodes, s_node, t_node, last_end;
    logic [CNT_W-1:0]          steps_inc;

    assign n_cnt_nodes = i_cfg.node_count;
    assign s_node      = i_cfg.source_node;
    assign t_node      = i_cfg.sink_node;

    assign pred_q   = r_pred[r_v];
    assign queue_q  = r_queue[r_head[NODE_W-1:0]];
    assign bn_idx   = (r_state == S_AUG_INIT) ? t_node : queue_q;
    assign bn_q     = r_bn[bn_idx];
    assign dist_idx = (r_state == S_BF_A) ? r_a : r_b;
    assign dist_q   = r_dist[dist_idx];

    assign resid = $signed({{(RES_W-CAP_W){1'b0}}, i_cap})
                 - $signed({i_flow[FLOW_W-1], i_flow});
    assign resid_pos = resid > 0;
    assign bn_new = (resid < $signed({r_bn_a[FLOW_W-1], r_bn_a}))
                  ? resid[FLOW_W-1:0] : r_bn_a;
    assign add_min = (resid < $signed({r_add[FLOW_W-1], r_add}))
                   ? resid : $signed({r_add[FLOW_W-1], r_add});
    assign newd = $signed({r_dist_a[DIST_W-1], r_dist_a})
                + $signed({{(DIST_W+1-CST_W){i_cost[CST_W-1]}}, i_cost});
    assign fnew_c   = i_flow + r_add;
    assign prod_c   = i_flow * i_cost;
    assign steps_inc = r_steps + CNT_W'(1);
    assign st_ok = (s_node != NODE_ZERO) && (s_node <= n_cnt_nodes)
                && (t_node != NODE_ZERO) && (t_node <= n_cnt_nodes)
                && (s_node != t_node);
    assign last_end = bf_take ? r_b : r_last;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_OUT) && i_res_ready;
    assign o_res.total_flow = r_total;
    assign o_res.total_cost = r_acc;

    always_comb begin
        case (r_state)
            S_AUG_RD, S_CYC_RD, S_PSH_RD: o_rd_addr = {r_u, r_v};
            default:                      o_rd_addr = {r_a, r_b};
        endcase
    end

    always_comb begin
        o_wr = '0;
        case (r_state)
            S_CLR: begin
                o_wr.cap_we  = 1'b1;
                o_wr.cost_we = 1'b1;
                o_wr.addr    = r_cnt;
            end
            S_ADD1: begin
                o_wr.cap_we  = 1'b1;
                o_wr.cost_we = 1'b1;
                o_wr.addr    = {r_eu, r_ev};
                o_wr.cap_d   = r_ecap;
                o_wr.cost_d  = $signed({r_ecost[COST_W-1], r_ecost});
            end
            S_ADD2: begin
                o_wr.cost_we = 1'b1;
                o_wr.addr    = {r_ev, r_eu};
                o_wr.cost_d  = -$signed({r_ecost[COST_W-1], r_ecost});
            end
            S_FCLR: begin
                o_wr.flow_we = 1'b1;
                o_wr.addr    = r_cnt;
            end
            S_AUG_EV, S_PSH_EV: begin
                o_wr.flow_we = 1'b1;
                o_wr.addr    = {r_u, r_v};
                o_wr.flow_d  = fnew_c;
            end
            S_AUG_W2, S_PSH_W2: begin
                o_wr.flow_we = 1'b1;
                o_wr.addr    = {r_v, r_u};
                o_wr.flow_d  = -r_fnew;
            end
            default: begin
                o_wr = '0;
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_a      = r_a;
        n_b      = r_b;
        n_u      = r_u;
        n_v      = r_v;
        n_x      = r_x;
        n_pass   = r_pass;
        n_last   = r_last;
        n_head   = r_head;
        n_tail   = r_tail;
        n_steps  = r_steps;
        n_add    = r_add;
        n_bn_a   = r_bn_a;
        n_fnew   = r_fnew;
        n_dist_a = r_dist_a;
        n_total  = r_total;
        n_acc    = r_prod_v ? r_acc + $signed({{(TCOST_W-PROD_W){r_prod[PROD_W-1]}}, r_prod})
                            : r_acc;
        n_prod   = r_prod;
        n_prod_v = 1'b0;
        n_eu     = r_eu;
        n_ev     = r_ev;
        n_ecap   = r_ecap;
        n_ecost  = r_ecost;
        init_bfs = 1'b0;
        init_bf  = 1'b0;
        bfs_take = 1'b0;
        bf_take  = 1'b0;

        case (r_state)
            S_CLR: begin
                n_cnt = r_cnt + ADDR_W'(1);
                if (&r_cnt) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_eu    = i_in_data.edge_from;
                    n_ev    = i_in_data.edge_to;
                    n_ecap  = i_in_data.edge_capacity;
                    n_ecost = i_in_data.unit_cost;
                    n_cnt   = '0;
                    case (i_in_data.action)
                        ACT_CLEAR: n_state = S_CLR;
                        ACT_ADD: begin
                            // drop edges touching vertex zero and self-loops
                            if (i_in_data.edge_from != NODE_ZERO
                                && i_in_data.edge_to != NODE_ZERO
                                && i_in_data.edge_from != i_in_data.edge_to) begin
                                n_state = S_ADD1;
                            end
                        end
                        ACT_SOLVE: n_state = S_FCLR;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD1: n_state = S_ADD2;
            S_ADD2: n_state = S_IDLE;
            S_FCLR: begin
                n_cnt = r_cnt + ADDR_W'(1);
                if (&r_cnt) begin
                    n_total = '0;
                    n_state = st_ok ? S_BFS_INIT : S_BF_INIT;
                end
            end
            S_BFS_INIT: begin
                init_bfs = 1'b1;
                n_head   = '0;
                n_tail   = CNT_W'(1);
                n_state  = S_BFS_DEQ;
            end
            S_BFS_DEQ: begin
                if (r_visited[t_node]) begin
                    n_state = S_AUG_INIT;
                end else if (r_head < r_tail) begin
                    n_a     = queue_q;
                    n_bn_a  = bn_q;
                    n_head  = r_head + CNT_W'(1);
                    n_b     = NODE_ONE;
                    n_state = S_BFS_RD;
                end else begin
                    n_state = S_BF_INIT;
                end
            end
            S_BFS_RD: n_state = S_BFS_EV;
            S_BFS_EV: begin
                bfs_take = !r_visited[r_b] && resid_pos && (r_tail < CNT_MAX);
                if (bfs_take) begin
                    n_tail = r_tail + CNT_W'(1);
                end
                if (r_b == n_cnt_nodes) begin
                    n_state = S_BFS_DEQ;
                end else begin
                    n_b     = r_b + NODE_ONE;
                    n_state = S_BFS_RD;
                end
            end
            S_AUG_INIT: begin
                n_add   = bn_q;
                n_v     = t_node;
                n_steps = '0;
                n_state = S_AUG_CHK;
            end
            S_AUG_CHK: begin
                if (r_v != s_node && r_steps < CNT_MAX) begin
                    n_u     = pred_q;
                    n_state = S_AUG_RD;
                end else begin
                    n_total = r_total + r_add[TFLOW_W-1:0];
                    n_state = S_BFS_INIT;
                end
            end
            S_AUG_RD: n_state = S_AUG_EV;
            S_AUG_EV: begin
                n_fnew  = fnew_c;
                n_state = S_AUG_W2;
            end
            S_AUG_W2: begin
                n_v     = r_u;
                n_steps = steps_inc;
                n_state = S_AUG_CHK;
            end
            S_BF_INIT: begin
                init_bf = 1'b1;
                n_pass  = '0;
                n_last  = '0;
                n_state = S_BF_PASS;
            end
            S_BF_PASS: begin
                if (r_pass < n_cnt_nodes) begin
                    n_last  = '0;
                    n_a     = NODE_ONE;
                    n_state = S_BF_A;
                end else begin
                    n_v     = r_last;
                    n_steps = '0;
                    n_state = S_LOC;
                end
            end
            S_BF_A: begin
                n_dist_a = dist_q;
                n_b      = NODE_ONE;
                n_state  = S_BF_RD;
            end
            S_BF_RD: n_state = S_BF_EV;
            S_BF_EV: begin
                bf_take = resid_pos && (newd < $signed({dist_q[DIST_W-1], dist_q}));
                n_last  = last_end;
                if (r_b != n_cnt_nodes) begin
                    n_b     = r_b + NODE_ONE;
                    n_state = S_BF_RD;
                end else if (r_a != n_cnt_nodes) begin
                    n_a     = r_a + NODE_ONE;
                    n_state = S_BF_A;
                end else if (last_end == NODE_ZERO) begin
                    n_state = S_SUM_INIT;
                end else begin
                    n_pass  = r_pass + NODE_ONE;
                    n_state = S_BF_PASS;
                end
            end
            S_LOC: begin
                // walk back far enough to land on the cycle itself
                if (r_steps == {1'b0, n_cnt_nodes}) begin
                    n_x     = r_v;
                    n_add   = BN_INF;
                    n_steps = '0;
                    n_state = (r_v == NODE_ZERO) ? S_SUM_INIT : S_CYC_P;
                end else if (pred_q == NODE_ZERO) begin
                    n_state = S_SUM_INIT;
                end else begin
                    n_v     = pred_q;
                    n_steps = steps_inc;
                end
            end
            S_CYC_P: begin
                n_u     = pred_q;
                n_state = S_CYC_RD;
            end
            S_CYC_RD: n_state = S_CYC_EV;
            S_CYC_EV: begin
                n_add   = add_min[FLOW_W-1:0];
                n_v     = r_u;
                n_steps = steps_inc;
                if (r_u != r_x && steps_inc <= {1'b0, n_cnt_nodes}) begin
                    n_state = S_CYC_P;
                end else if (r_u != r_x || add_min <= 0) begin
                    n_state = S_SUM_INIT;
                end else begin
                    n_state = S_PSH_P;
                end
            end
            S_PSH_P: begin
                n_u     = pred_q;
                n_state = S_PSH_RD;
            end
            S_PSH_RD: n_state = S_PSH_EV;
            S_PSH_EV: begin
                n_fnew  = fnew_c;
                n_state = S_PSH_W2;
            end
            S_PSH_W2: begin
                n_v     = r_u;
                n_state = (r_u == r_x) ? S_BF_INIT : S_PSH_P;
            end
            S_SUM_INIT: begin
                n_acc = '0;
                n_a   = NODE_ONE;
                n_b   = NODE_ONE;
                n_state = (n_cnt_nodes == NODE_ZERO) ? S_SUM_END : S_SUM_RD;
            end
            S_SUM_RD: n_state = S_SUM_EV;
            S_SUM_EV: begin
                n_prod   = prod_c;
                n_prod_v = (i_flow > 0);
                if (r_b != n_cnt_nodes) begin
                    n_b     = r_b + NODE_ONE;
                    n_state = S_SUM_RD;
                end else if (r_a != n_cnt_nodes) begin
                    n_a     = r_a + NODE_ONE;
                    n_b     = NODE_ONE;
                    n_state = S_SUM_RD;
                end else begin
                    n_state = S_SUM_END;
                end
            end
            S_SUM_END: n_state = S_OUT;
            S_OUT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_cnt    <= '0;
            r_prod_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_prod_v <= n_prod_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a      <= n_a;
        r_b      <= n_b;
        r_u      <= n_u;
        r_v      <= n_v;
        r_x      <= n_x;
        r_pass   <= n_pass;
        r_last   <= n_last;
        r_head   <= n_head;
        r_tail   <= n_tail;
        r_steps  <= n_steps;
        r_add    <= n_add;
        r_bn_a   <= n_bn_a;
        r_fnew   <= n_fnew;
        r_dist_a <= n_dist_a;
        r_total  <= n_total;
        r_acc    <= n_acc;
        r_prod   <= n_prod;
        r_eu     <= n_eu;
        r_ev     <= n_ev;
        r_ecap   <= n_ecap;
        r_ecost  <= n_ecost;
    end

    always_ff @(posedge i_clk) begin
        if (init_bfs) begin
            r_visited      <= MAX_NODES'(1) << s_node;
            r_pred[s_node] <= s_node;
            r_bn[s_node]   <= BN_INF;
            r_queue[0]     <= s_node;
        end
        if (bfs_take) begin
            r_visited[r_b]                 <= 1'b1;
            r_pred[r_b]                    <= r_a;
            r_bn[r_b]                      <= bn_new;
            r_queue[r_tail[NODE_W-1:0]]    <= r_b;
        end
        if (init_bf) begin
            for (int i = 0; i < MAX_NODES; i++) begin
                r_dist[i] <= '0;
                r_pred[i] <= '0;
            end
        end
        if (bf_take) begin
            r_dist[r_b] <= newd[DIST_W-1:0];
            r_pred[r_b] <= r_a;
        end
    end

endmodule

// ----- tb/sv/flow_result_checker.sv -----
`timescale 1ns / 1ps

module flow_result_checker
    import mcmf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  t_in_item             i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_out_item            i_out_data,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [NODE_W-1:0]    i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam int BIG_BOTTLENECK = 32'h7fffffff;

    int    cap_mat [MAX_NODES][MAX_NODES];
    int    cost_mat[MAX_NODES][MAX_NODES];
    int    flow_mat[MAX_NODES][MAX_NODES];
    longint dist_v [MAX_NODES];
    int    pred    [MAX_NODES];
    int    bneck   [MAX_NODES];
    bit    seen    [MAX_NODES];
    int    bfs_q   [MAX_NODES];

    logic [NODE_W-1:0] node_cnt;
    logic [NODE_W-1:0] src_node;
    logic [NODE_W-1:0] snk_node;

    t_out_item expected_results[$];

    assign o_pending = expected_results.size();

    function automatic int residual(int a, int b);
        return cap_mat[a][b] - flow_mat[a][b];
    endfunction

    task automatic clear_edges();
        foreach (cap_mat[a, b]) begin
            cap_mat[a][b]  = 0;
            cost_mat[a][b] = 0;
        end
    endtask

    task automatic augment_max_flow(input int n, input int s, input int t,
                                    output int unsigned total);
        int head, tail, a, b, r, add, v, u, steps;
        total = 0;
        forever begin
            head = 0;
            tail = 0;
            foreach (seen[i]) seen[i] = 0;
            seen[s]  = 1;
            pred[s]  = s;
            bneck[s] = BIG_BOTTLENECK;
            bfs_q[tail++] = s;
            while (head < tail && !seen[t]) begin
                a = bfs_q[head++];
                for (b = 1; b <= n; b++) begin
                    r = residual(a, b);
                    if (!seen[b] && r > 0 && tail < MAX_NODES) begin
                        seen[b]  = 1;
                        pred[b]  = a;
                        bneck[b] = (r < bneck[a]) ? r : bneck[a];
                        bfs_q[tail++] = b;
                    end
                end
            end
            if (!seen[t]) break;
            add   = bneck[t];
            v     = t;
            steps = 0;
            while (v != s && steps < MAX_NODES) begin
                u = pred[v];
                flow_mat[u][v] += add;
                flow_mat[v][u] -= add;
                v = u;
                steps++;
            end
            total += add;
        end
    endtask

    // Return a vertex on a negative residual loop, or zero when none is left.
    function automatic int locate_negative_loop(int n);
        int a, b, pass, last, x;
        last = 0;
        for (a = 0; a < MAX_NODES; a++) begin
            dist_v[a] = 0;
            pred[a]   = 0;
        end
        for (pass = 0; pass < n; pass++) begin
            last = 0;
            for (a = 1; a <= n; a++)
                for (b = 1; b <= n; b++)
                    if (residual(a, b) > 0 && dist_v[a] + cost_mat[a][b] < dist_v[b]) begin
                        dist_v[b] = dist_v[a] + cost_mat[a][b];
                        pred[b]   = a;
                        last      = b;
                    end
            if (last == 0) return 0;
        end
        x = last;
        for (pass = 0; pass < n; pass++) begin
            x = pred[x];
            if (x == 0) return 0;
        end
        return x;
    endfunction

    task automatic cancel_negative_loops(input int n);
        int x, add, v, u, r, steps;
        x = locate_negative_loop(n);
        while (x != 0) begin
            add   = BIG_BOTTLENECK;
            v     = x;
            steps = 0;
            do begin
                u = pred[v];
                r = residual(u, v);
                if (r < add) add = r;
                v = u;
                steps++;
            end while (v != x && steps <= n);
            if (v != x || add <= 0) return;
            v = x;
            do begin
                u = pred[v];
                flow_mat[u][v] += add;
                flow_mat[v][u] -= add;
                v = u;
            end while (v != x);
            x = locate_negative_loop(n);
        end
    endtask

    task automatic solve_graph(output t_out_item res);
        int n, s, t, a, b;
        int unsigned fl;
        longint cst;
        n   = node_cnt;
        s   = src_node;
        t   = snk_node;
        fl  = 0;
        cst = 0;
        if (n > MAX_NODES - 1) n = MAX_NODES - 1;
        foreach (flow_mat[i, j]) flow_mat[i][j] = 0;
        if (s >= 1 && s <= n && t >= 1 && t <= n && s != t)
            augment_max_flow(n, s, t, fl);
        cancel_negative_loops(n);
        for (a = 1; a <= n; a++)
            for (b = 1; b <= n; b++)
                if (flow_mat[a][b] > 0)
                    cst += longint'(flow_mat[a][b]) * cost_mat[a][b];
        res.total_flow = fl[TFLOW_W-1:0];
        res.total_cost = cst[TCOST_W-1:0];
    endtask

    task automatic apply_request(input t_in_item req);
        int u, v, p;
        t_out_item res;
        u = req.edge_from;
        v = req.edge_to;
        p = int'($signed(req.unit_cost));
        case (req.action)
            ACT_CLEAR: clear_edges();
            ACT_ADD: begin
                if (u != 0 && v != 0 && u < MAX_NODES && v < MAX_NODES && u != v) begin
                    cap_mat[u][v]  = req.edge_capacity;
                    cost_mat[u][v] = p;
                    cost_mat[v][u] = -p;
                end
            end
            ACT_SOLVE: begin
                solve_graph(res);
                expected_results.push_back(res);
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            clear_edges();
            foreach (flow_mat[i, j]) flow_mat[i][j] = 0;
            node_cnt = 5'd31;
            src_node = 5'd1;
            snk_node = 5'd2;
            expected_results.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected: flow %0d cost %0d",
                           i_out_data.total_flow, i_out_data.total_cost);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_data.total_flow !== want.total_flow) begin
                        $error("total_flow: expected %0d, actual %0d",
                               want.total_flow, i_out_data.total_flow);
                        o_fail_count++;
                    end
                    if (i_out_data.total_cost !== want.total_cost) begin
                        $error("total_cost: expected %0d, actual %0d",
                               want.total_cost, i_out_data.total_cost);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_NODE_COUNT: node_cnt = i_cfg_data;
                    CFG_SOURCE:     src_node = i_cfg_data;
                    CFG_SINK:       snk_node = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) apply_request(i_in_data);
        end
    end

endmodule

// ----- tb/sv/tb_min_cost_max_flow_top.sv -----
`timescale 1ns / 1ps

module tb_min_cost_max_flow_top;
    import mcmf_pkg::*;

    localparam logic [1:0]           ACT_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int RANDOM_REQUESTS = 850;
    localparam int HOLD_CYCLES     = 6000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in_item             i_in_data;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out_item            o_out_data;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [NODE_W-1:0]    i_cfg_data;

    int fail_count;
    int pending;
    logic in_taken;
    logic cfg_taken;
    bit quiet;
    bit hold_go;
    bit hold_done;
    int n_solves, n_edges, n_clears, n_cfg, n_requests;
    int cur_nodes;

    min_cost_max_flow_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    flow_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Handshake outcome of the last rising edge, read back at the falling edge.
    always @(posedge i_clk) begin
        in_taken  <= i_in_valid && !o_in_stall;
        cfg_taken <= i_cfg_valid && o_cfg_ready;
    end

    initial begin
        #400_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("Verification failed");
        $finish;
    end

    // Receiver: random stalls, one long hold-off on request.
    initial begin
        i_out_stall = 1'b0;
        hold_done   = 0;
        forever begin
            @(negedge i_clk);
            if (hold_go && !hold_done) begin
                i_out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1;
            end
            i_out_stall = quiet ? 1'b0 : ($urandom_range(0, 99) < 9);
        end
    end

    task automatic send_request(input logic [1:0] act, input logic [4:0] from_v,
                                input logic [4:0] to_v, input logic [15:0] cap,
                                input logic [15:0] cst);
        if (!quiet && $urandom_range(0, 99) < 9) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_in_valid              = 1'b1;
        i_in_data.action        = act;
        i_in_data.edge_from     = from_v;
        i_in_data.edge_to       = to_v;
        i_in_data.edge_capacity = cap;
        i_in_data.unit_cost     = cst;
        do @(negedge i_clk); while (!in_taken);
        case (act)
            ACT_CLEAR: n_clears++;
            ACT_ADD:   n_edges++;
            ACT_SOLVE: n_solves++;
            default: ;
        endcase
        if (act != ACT_UNUSED) n_requests++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [4:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(negedge i_clk); while (!cfg_taken);
        i_cfg_valid = 1'b0;
        n_cfg++;
    endtask

    // Hold the input quiet until every result is back and the block has settled.
    task automatic drain();
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (1100) @(negedge i_clk);
    endtask

    task automatic set_graph(input logic [4:0] n, input logic [4:0] s, input logic [4:0] t);
        drain();
        write_reg(CFG_NODE_COUNT, n);
        write_reg(CFG_SOURCE, s);
        write_reg(CFG_SINK, t);
        cur_nodes = (n < 2) ? 2 : n;
    endtask

    task automatic random_edge();
        logic [4:0]  u, v;
        logic [15:0] cap, cst;
        if ($urandom_range(0, 9) == 0) begin
            u = 5'($urandom_range(0, 31));
            v = 5'($urandom_range(0, 31));
        end else begin
            u = 5'($urandom_range(1, cur_nodes));
            v = 5'($urandom_range(1, cur_nodes));
        end
        case ($urandom_range(0, 9))
            0:       cap = 16'd0;
            1, 2:    cap = 16'($urandom_range(0, 65535));
            default: cap = 16'($urandom_range(1, 60));
        endcase
        cst = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                          : 16'($signed($urandom_range(0, 40)) - 20);
        send_request(ACT_ADD, u, v, cap, cst);
    endtask

    // One graph per pass: a burst of edges, then a solve; clears and junk now and then.
    task automatic random_phase(input int requests, input int max_edges);
        int stop_at;
        stop_at = n_requests + requests;
        send_request(ACT_CLEAR, 5'd0, 5'd0, 16'd0, 16'd0);
        while (n_requests < stop_at) begin
            repeat ($urandom_range(1, max_edges)) random_edge();
            if ($urandom_range(0, 19) == 0)
                send_request(ACT_UNUSED, 5'($urandom), 5'($urandom),
                             16'($urandom), 16'($urandom));
            if ($urandom_range(0, 24) == 0)
                send_request(ACT_CLEAR, 5'($urandom), 5'($urandom),
                             16'($urandom), 16'($urandom));
            send_request(ACT_SOLVE, 5'($urandom), 5'($urandom),
                         16'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_NODE_COUNT;
        i_cfg_data  = '0;
        quiet       = 0;
        hold_go     = 0;
        n_solves = 0; n_edges = 0; n_clears = 0; n_cfg = 0; n_requests = 0;
        cur_nodes = 31;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset graph settings, field extremes and ignored edges.
        send_request(ACT_ADD, 5'd1, 5'd2, 16'hffff, 16'h8000);
        send_request(ACT_ADD, 5'd0, 5'd3, 16'd9, 16'd1);
        send_request(ACT_ADD, 5'd3, 5'd0, 16'd9, 16'd1);
        send_request(ACT_ADD, 5'd5, 5'd5, 16'd9, 16'd1);
        send_request(ACT_ADD, 5'd1, 5'd31, 16'd0, 16'h7fff);
        send_request(ACT_ADD, 5'd31, 5'd2, 16'd40, 16'h7fff);
        send_request(ACT_ADD, 5'd1, 5'd31, 16'd30, 16'hfff0);
        send_request(ACT_UNUSED, 5'd31, 5'd31, 16'hffff, 16'hffff);
        send_request(ACT_SOLVE, 5'd0, 5'd0, 16'd0, 16'd0);
        send_request(ACT_ADD, 5'd1, 5'd2, 16'd100, 16'd5);
        send_request(ACT_ADD, 5'd2, 5'd3, 16'd50, 16'hfffd);
        send_request(ACT_ADD, 5'd3, 5'd1, 16'd50, 16'hfffd);
        send_request(ACT_SOLVE, 5'd0, 5'd0, 16'd0, 16'd0);
        send_request(ACT_CLEAR, 5'd31, 5'd31, 16'hffff, 16'hffff);
        send_request(ACT_SOLVE, 5'd0, 5'd0, 16'd0, 16'd0);
        set_graph(5'd3, 5'd2, 5'd2);
        send_request(ACT_ADD, 5'd1, 5'd2, 16'd7, 16'hffff);
        send_request(ACT_ADD, 5'd2, 5'd1, 16'd7, 16'hffff);
        send_request(ACT_SOLVE, 5'd0, 5'd0, 16'd0, 16'd0);
        set_graph(5'd0, 5'd1, 5'd2);
        send_request(ACT_SOLVE, 5'd0, 5'd0, 16'd0, 16'd0);
        drain();
        write_reg(CFG_UNUSED, 5'd31);

        set_graph(5'd2, 5'd1, 5'd2);
        random_phase(60, 3);
        set_graph(5'd5, 5'd1, 5'd5);
        hold_go = 1;
        random_phase(160, 6);
        set_graph(5'd8, 5'd2, 5'd7);
        quiet = 1;
        random_phase(120, 8);
        quiet = 0;
        set_graph(5'd6, 5'd4, 5'd4);
        random_phase(80, 6);
        set_graph(5'd4, 5'd9, 5'd1);
        random_phase(80, 5);
        set_graph(5'd1, 5'd1, 5'd0);
        random_phase(30, 3);
        set_graph(5'd31, 5'd31, 5'd1);
        random_phase(25, 10);
        set_graph(5'd7, 5'd1, 5'd3);
        random_phase(300, 6);

        drain();
        $display("covered %0d requests: %0d edges, %0d solves, %0d clears, %0d register writes",
                 n_requests, n_edges, n_solves, n_clears, n_cfg);
        $display("graph sizes 0 to 31 vertices, output hold-off of %0d cycles", HOLD_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
